FILE: design/lfsa_pkg.sv
// Shared types and constants for the lowest free slot allocator.
// No dependencies; used by every module of the block.
package lfsa_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int WORD_W    = 32;
  localparam int NUM_WORDS = MAX_SLOTS / WORD_W;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int WSEL_W    = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int SLOT_W    = 9;
  localparam int STATUS_W  = 2;
  localparam int CMP_W     = (SLOT_W > IDX_W + 1) ? SLOT_W : IDX_W + 1;
  localparam logic [SLOT_W-1:0] COUNT_RESET = SLOT_W'(256);

  typedef enum logic [0:0] {
    KIND_RESERVE = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY       = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } status_t;

  typedef struct packed {
    logic [0:0]        kind;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   granted_slot;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_FIND = 2'd1,
    S_EXEC = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic find;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/lfsa_ctrl.sv
// Controller state machine of the lowest free slot allocator.
// Depends on lfsa_pkg; drives the datapath through dp_cmd_t.
module lfsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lfsa_pkg::dp_status_t dp_status,
  output lfsa_pkg::dp_cmd_t   dp_cmd
);

  lfsa_pkg::state_t state_r;
  lfsa_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfsa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lfsa_pkg::S_IDLE: begin
        if (in_valid) state_nxt = lfsa_pkg::S_FIND;
      end
      lfsa_pkg::S_FIND: begin
        state_nxt = lfsa_pkg::S_EXEC;
      end
      lfsa_pkg::S_EXEC: begin
        if (dp_status.out_free) state_nxt = lfsa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = lfsa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    dp_cmd.load   = 1'b0;
    dp_cmd.find   = 1'b0;
    dp_cmd.commit = 1'b0;
    case (state_r)
      lfsa_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        dp_cmd.load = in_valid;
      end
      lfsa_pkg::S_FIND: begin
        dp_cmd.find = 1'b1;
      end
      lfsa_pkg::S_EXEC: begin
        dp_cmd.commit = dp_status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfsa_pkg::S_EXEC && !dp_status.out_free) |=> (state_r == lfsa_pkg::S_EXEC))
    else $error("exec state left without a free output register");

endmodule

FILE: design/lfsa_dp.sv
// Datapath of the lowest free slot allocator: taken map, full-word summary,
// request and output registers. Depends on lfsa_pkg; driven by lfsa_ctrl.
module lfsa_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lfsa_pkg::in_item_t       in_data,
  input  logic                     cfg_wr_en,
  input  logic [lfsa_pkg::SLOT_W-1:0] cfg_wr_data,
  input  lfsa_pkg::dp_cmd_t        dp_cmd,
  output lfsa_pkg::dp_status_t     dp_status,
  output logic                     out_valid,
  input  logic                     out_stall,
  output lfsa_pkg::out_item_t      out_data
);

  logic [lfsa_pkg::WORD_W-1:0]    map_r [lfsa_pkg::NUM_WORDS];
  logic [lfsa_pkg::NUM_WORDS-1:0] full_r;
  logic [lfsa_pkg::SLOT_W-1:0]    slot_count_r;
  logic [0:0]                     req_kind_r;
  logic [lfsa_pkg::SLOT_W-1:0]    req_slot_r;
  logic [lfsa_pkg::WSEL_W-1:0]    wsel_r;
  logic [lfsa_pkg::WSEL_W-1:0]    wsel_nxt;
  logic                           any_free_r;
  logic                           any_free_nxt;
  logic                           out_valid_r;
  lfsa_pkg::out_item_t            out_r;

  logic [lfsa_pkg::CMP_W-1:0]     count_ext;
  logic [lfsa_pkg::CMP_W-1:0]     count_eff;
  logic [lfsa_pkg::SLOT_W-1:0]    rel_idx9;
  logic [lfsa_pkg::IDX_W-1:0]     rel_idx;
  logic                           rel_in_range;
  logic [lfsa_pkg::WORD_W-1:0]    word;
  logic [lfsa_pkg::BIT_W-1:0]     free_bit;
  logic [lfsa_pkg::IDX_W-1:0]     res_idx;
  logic                           res_ok;
  logic                           rel_ok;
  logic [lfsa_pkg::WORD_W-1:0]    word_nxt;
  lfsa_pkg::out_item_t            result;
  logic                           out_free;
  logic [lfsa_pkg::NUM_WORDS-1:0] full_calc;

  assign count_ext = lfsa_pkg::CMP_W'(slot_count_r);
  assign count_eff = (count_ext > lfsa_pkg::CMP_W'(lfsa_pkg::MAX_SLOTS)) ?
                     lfsa_pkg::CMP_W'(lfsa_pkg::MAX_SLOTS) : count_ext;

  assign rel_idx9     = req_slot_r - lfsa_pkg::SLOT_W'(1);
  assign rel_idx      = rel_idx9[lfsa_pkg::IDX_W-1:0];
  assign rel_in_range = (req_slot_r != '0) &&
                        (lfsa_pkg::CMP_W'(req_slot_r) <= count_eff);

  always_comb begin
    wsel_nxt     = '0;
    any_free_nxt = 1'b0;
    for (int i = lfsa_pkg::NUM_WORDS - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        wsel_nxt     = lfsa_pkg::WSEL_W'(i);
        any_free_nxt = 1'b1;
      end
    end
    if (req_kind_r == lfsa_pkg::KIND_RELEASE) begin
      wsel_nxt = rel_idx[lfsa_pkg::IDX_W-1:lfsa_pkg::BIT_W];
    end
  end

  assign word = map_r[wsel_r];

  always_comb begin
    free_bit = '0;
    for (int b = lfsa_pkg::WORD_W - 1; b >= 0; b--) begin
      if (!word[b]) free_bit = lfsa_pkg::BIT_W'(b);
    end
  end

  assign res_idx = {wsel_r, free_bit};
  assign res_ok  = any_free_r &&
                   (lfsa_pkg::CMP_W'(res_idx) < count_eff);
  assign rel_ok  = rel_in_range && word[rel_idx[lfsa_pkg::BIT_W-1:0]];

  always_comb begin
    word_nxt = word;
    result.granted_slot = '0;
    result.status       = lfsa_pkg::ST_OK;
    if (req_kind_r == lfsa_pkg::KIND_RESERVE) begin
      if (res_ok) begin
        word_nxt[free_bit]  = 1'b1;
        result.granted_slot = lfsa_pkg::SLOT_W'(res_idx) + lfsa_pkg::SLOT_W'(1);
      end else begin
        result.status = lfsa_pkg::ST_EMPTY;
      end
    end else begin
      if (rel_ok) begin
        word_nxt[rel_idx[lfsa_pkg::BIT_W-1:0]] = 1'b0;
      end else begin
        result.status = lfsa_pkg::ST_BAD_RELEASE;
      end
    end
  end

  assign out_free           = !out_valid_r || !out_stall;
  assign dp_status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < lfsa_pkg::NUM_WORDS; w++) begin
        map_r[w] <= '0;
      end
      full_r       <= '0;
      slot_count_r <= lfsa_pkg::COUNT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) slot_count_r <= cfg_wr_data;
      if (dp_cmd.commit) begin
        map_r[wsel_r]  <= word_nxt;
        full_r[wsel_r] <= &word_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      req_kind_r <= in_data.kind;
      req_slot_r <= in_data.slot;
    end
    if (dp_cmd.find) begin
      wsel_r     <= wsel_nxt;
      any_free_r <= any_free_nxt;
    end
    if (dp_cmd.commit) out_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    for (int w = 0; w < lfsa_pkg::NUM_WORDS; w++) begin
      full_calc[w] = &map_r[w];
    end
  end

  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    full_r == full_calc)
    else $error("full-word summary out of step with taken map");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.commit |-> out_free)
    else $error("result loaded over a pending transaction");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.granted_slot != '0) |-> (out_r.status == lfsa_pkg::ST_OK))
    else $error("slot granted with a failure status");

  a_grant_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.commit && req_kind_r == lfsa_pkg::KIND_RESERVE && res_ok)
      |=> map_r[$past(wsel_r)][$past(free_bit)])
    else $error("granted slot not marked taken");

endmodule

FILE: design/lowest_free_slot_allocator_top.sv
// Top level of the lowest free slot allocator.
// Depends on lfsa_pkg; instantiates lfsa_ctrl and lfsa_dp.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data): each transaction is a reserve
//   (kind 0) or a release of in_data.slot (kind 1). Result channel (out_valid,
//   out_stall, out_data): exactly one transaction per request, in order, with
//   the granted slot (zero unless a reserve succeeds) and a status: ok, no
//   free slot, or invalid release ignored.
//   cfg_wr_en/cfg_wr_data set the slot count (0..256 in use, larger values
//   saturate to 256); write it only while no request is in flight.
//   Flow: a request is accepted into the request registers, then passes the
//   word-select and word-update steps over the taken map (8 words of 32 bits
//   with a summary of full words); the update loads the result register. A new
//   request is accepted only after the previous one has left its update step.
//   Reset: rst_n low clears the whole taken map at once, sets the count to 256
//   and drops out_valid; the block takes requests in the next cycle.
//   Stall: the result register holds while out_stall is high; one more request
//   may be accepted and waits in its update step until the register frees.
module lowest_free_slot_allocator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lfsa_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lfsa_pkg::out_item_t         out_data,
  input  logic                        cfg_wr_en,
  input  logic [lfsa_pkg::SLOT_W-1:0] cfg_wr_data
);

  lfsa_pkg::dp_cmd_t    dp_cmd;
  lfsa_pkg::dp_status_t dp_status;

  lfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  lfsa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .dp_cmd      (dp_cmd),
    .dp_status   (dp_status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

FILE: tb/sv/tb_lowest_free_slot_allocator_top.sv
// Self-checking testbench for lowest_free_slot_allocator_top.
// Drives reserve and release transactions under random idling, checking results
// against an in-bench slot map or the script; depends on lfsa_pkg and the RTL only.
module tb_lowest_free_slot_allocator_top;
  import lfsa_pkg::*;

  localparam int LONG_HOLD = 200;
  localparam int PHASES    = 11;
  localparam int RUN_LIMIT = 2_000_000;

  typedef struct packed {
    bit                cfg;
    kind_t             kind;
    logic [SLOT_W-1:0] arg;
    bit                known;
    logic [SLOT_W-1:0] granted;
    status_t           status;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_wr_en;
  logic [SLOT_W-1:0] cfg_wr_data;

  bit                taken_slots [1:MAX_SLOTS];
  logic [SLOT_W-1:0] slot_count_shadow;
  out_item_t         grant_q [$];

  bit tx_steady;
  bit rx_steady;
  bit hold_request;
  int mismatches;
  int requests_sent;
  int settings_used;
  int n_granted;
  int n_empty;
  int n_rejected;

  script_row_t script [26] = '{
    '{1'b0, KIND_RESERVE, 0,   1'b1, 1, ST_OK},
    '{1'b0, KIND_RESERVE, 511, 1'b1, 2, ST_OK},
    '{1'b0, KIND_RESERVE, 0,   1'b0, 0, ST_OK},
    '{1'b0, KIND_RELEASE, 0,   1'b1, 0, ST_BAD_RELEASE},
    '{1'b0, KIND_RELEASE, 511, 1'b1, 0, ST_BAD_RELEASE},
    '{1'b0, KIND_RELEASE, 256, 1'b1, 0, ST_BAD_RELEASE},
    '{1'b0, KIND_RELEASE, 2,   1'b1, 0, ST_OK},
    '{1'b0, KIND_RELEASE, 2,   1'b1, 0, ST_BAD_RELEASE},
    '{1'b0, KIND_RESERVE, 0,   1'b1, 2, ST_OK},
    '{1'b1, KIND_RESERVE, 2,   1'b0, 0, ST_OK},
    '{1'b0, KIND_RESERVE, 0,   1'b1, 0, ST_EMPTY},
    '{1'b0, KIND_RELEASE, 3,   1'b1, 0, ST_BAD_RELEASE},
    '{1'b0, KIND_RELEASE, 1,   1'b1, 0, ST_OK},
    '{1'b0, KIND_RESERVE, 0,   1'b1, 1, ST_OK},
    '{1'b1, KIND_RESERVE, 0,   1'b0, 0, ST_OK},
    '{1'b0, KIND_RESERVE, 0,   1'b1, 0, ST_EMPTY},
    '{1'b0, KIND_RELEASE, 1,   1'b1, 0, ST_BAD_RELEASE},
    '{1'b1, KIND_RESERVE, 511, 1'b0, 0, ST_OK},
    '{1'b0, KIND_RELEASE, 3,   1'b0, 0, ST_OK},
    '{1'b0, KIND_RESERVE, 0,   1'b0, 0, ST_OK},
    '{1'b0, KIND_RESERVE, 0,   1'b0, 0, ST_OK},
    '{1'b1, KIND_RESERVE, 1,   1'b0, 0, ST_OK},
    '{1'b0, KIND_RESERVE, 0,   1'b0, 0, ST_OK},
    '{1'b0, KIND_RELEASE, 1,   1'b0, 0, ST_OK},
    '{1'b0, KIND_RESERVE, 0,   1'b0, 0, ST_OK},
    '{1'b1, KIND_RESERVE, 256, 1'b0, 0, ST_OK}
  };

  lowest_free_slot_allocator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic int usable_slots();
    return (slot_count_shadow > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count_shadow);
  endfunction

  function automatic out_item_t predict_grant(in_item_t req);
    out_item_t res;
    int        lim;
    int        s;
    lim = usable_slots();
    s = int'(req.slot);
    res.granted_slot = '0;
    if (req.kind == KIND_RESERVE) begin
      res.status = ST_EMPTY;
      for (int i = 1; i <= lim; i++) begin
        if (!taken_slots[i]) begin
          taken_slots[i] = 1'b1;
          res.granted_slot = SLOT_W'(i);
          res.status = ST_OK;
          break;
        end
      end
    end else if (s >= 1 && s <= lim && taken_slots[s]) begin
      taken_slots[s] = 1'b0;
      res.status = ST_OK;
    end else begin
      res.status = ST_BAD_RELEASE;
    end
    return res;
  endfunction

  function automatic int pick_taken_slot();
    int n;
    int k;
    n = 0;
    for (int i = 1; i <= usable_slots(); i++) if (taken_slots[i]) n++;
    if (n == 0) return 0;
    k = $urandom_range(1, n);
    for (int i = 1; i <= usable_slots(); i++) begin
      if (taken_slots[i]) begin
        k--;
        if (k == 0) return i;
      end
    end
    return 0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_grant(out_item_t got);
    out_item_t want;
    if (grant_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got slot %0d status %0d",
               $time, got.granted_slot, got.status);
      mismatches++;
      return;
    end
    want = grant_q.pop_front();
    if (got.granted_slot !== want.granted_slot) begin
      $display("%0t: granted_slot expected %0d got %0d",
               $time, want.granted_slot, got.granted_slot);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
      mismatches++;
    end
    case (want.status)
      ST_OK:    if (want.granted_slot != 0) n_granted++;
      ST_EMPTY: n_empty++;
      default:  n_rejected++;
    endcase
  endfunction

  task automatic issue(input in_item_t req, input bit known = 1'b0,
                       input out_item_t typed_res = '0);
    out_item_t predicted;
    int        gap;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_grant(req);
    grant_q.push_back(known ? typed_res : predicted);
    requests_sent++;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_slot_count(input int value);
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= SLOT_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    slot_count_shadow = SLOT_W'(value);
    settings_used++;
  endtask

  task automatic mixed_phase(input int n);
    in_item_t req;
    int       r;
    int       s;
    repeat (n) begin
      r = $urandom_range(0, 99);
      req.kind = KIND_RESERVE;
      req.slot = SLOT_W'($urandom_range(0, 511));
      if (r >= 45) begin
        req.kind = KIND_RELEASE;
        s = pick_taken_slot();
        if (r < 82 && s != 0) req.slot = SLOT_W'(s);
        else if (r < 92) req.slot = SLOT_W'($urandom_range(0, usable_slots() + 2));
      end
      issue(req);
    end
  endtask

  task automatic fill_and_empty();
    in_item_t req;
    int       held [$];
    int       n_free;
    int       k;
    n_free = 0;
    for (int i = 1; i <= usable_slots(); i++) if (!taken_slots[i]) n_free++;
    // keep offering while the result side holds off
    tx_steady = 1'b1;
    hold_request = 1'b1;
    req.kind = KIND_RESERVE;
    repeat (n_free + 2) begin
      req.slot = SLOT_W'($urandom_range(0, 511));
      issue(req);
    end
    tx_steady = 1'b0;
    for (int i = 1; i <= usable_slots(); i++) if (taken_slots[i]) held.push_back(i);
    req.kind = KIND_RELEASE;
    while (held.size() != 0) begin
      k = $urandom_range(0, held.size() - 1);
      req.slot = SLOT_W'(held[k]);
      issue(req);
      if ($urandom_range(0, 7) == 0) issue(req);
      held.delete(k);
    end
  endtask

  initial begin : result_side
    int run;
    run = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_grant(out_data);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        run = LONG_HOLD;
      end else if (run > 0) begin
        run--;
      end else if (out_stall || rx_steady) begin
        out_stall <= 1'b0;
        run = rx_steady ? 0 : $urandom_range(0, 20);
      end else begin
        run = pick_gap();
        if (run > 0) out_stall <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    out_item_t typed_res;
    in_item_t  req;
    int        value;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    slot_count_shadow = COUNT_RESET;
    foreach (taken_slots[i]) taken_slots[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].cfg) begin
        set_slot_count(int'(script[i].arg));
      end else begin
        req.kind = script[i].kind;
        req.slot = script[i].arg;
        typed_res.granted_slot = script[i].granted;
        typed_res.status = script[i].status;
        issue(req, script[i].known, typed_res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: value = 1;
        1: value = 256;
        2: value = 0;
        3: value = 511;
        4: value = 257;
        default: value = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256)
                                                       : $urandom_range(2, 40);
      endcase
      set_slot_count(value);
      rx_steady = (ph % 4 == 3);
      tx_steady = (ph % 5 == 4);
      if (ph == 1) fill_and_empty();
      else mixed_phase(115);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end

    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d requests across %0d slot-count settings, from no slots to saturation.",
             requests_sent, settings_used);
    $display("Results: %0d grants, %0d with no free slot, %0d rejected releases.",
             n_granted, n_empty, n_rejected);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #RUN_LIMIT;
    $display("Timeout with %0d results outstanding", grant_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
